[rtl/core/cji_pkg.sv]
// Shared types and constants for the constrained jerk integrator.
// Used by the channel interfaces and the top level; depends on nothing.
package cji_pkg;

   localparam int AXIS_W     = 2;
   localparam int VAL_W      = 20;
   localparam int SUM_W      = 40;
   localparam int DT_W       = 24;
   localparam int MARGIN_W   = 16;
   localparam int LANE_W     = 20;
   localparam int PACKED_W   = 60;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 60;

   typedef logic [AXIS_W-1:0]       axis_type;
   typedef logic signed [VAL_W-1:0] value_type;
   typedef logic [CSR_IDX_W-1:0]    csr_index_type;

   // Register indexes of the control port.
   localparam csr_index_type REG_STEP_TIME     = 3'd0;
   localparam csr_index_type REG_SAFETY_MARGIN = 3'd1;
   localparam csr_index_type REG_JERK_MAX      = 3'd2;
   localparam csr_index_type REG_ACCEL_MAX     = 3'd3;
   localparam csr_index_type REG_VELOCITY_MAX  = 3'd4;
   localparam csr_index_type REG_POSITION_MIN  = 3'd5;
   localparam csr_index_type REG_POSITION_MAX  = 3'd6;

   localparam logic [DT_W-1:0] STEP_TIME_RESET = 24'd16777;

endpackage

[rtl/core/cji_req_if.sv]
// Request channel of the constrained jerk integrator: valid, ready and one jerk item.
// Depends on cji_pkg.
interface cji_req_if;
   import cji_pkg::*;

   logic      valid;
   logic      ready;
   axis_type  axis;
   logic      first_sample;
   value_type jerk_sample;
   value_type init_accel;
   value_type init_velocity;
   value_type init_position;

   modport source (
      output valid, axis, first_sample, jerk_sample, init_accel, init_velocity,
             init_position,
      input  ready
   );

   modport sink (
      input  valid, axis, first_sample, jerk_sample, init_accel, init_velocity,
             init_position,
      output ready
   );

endinterface

[rtl/core/cji_rsp_if.sv]
// Response channel of the constrained jerk integrator: valid, ready and one result item.
// Depends on cji_pkg.
interface cji_rsp_if;
   import cji_pkg::*;

   logic      valid;
   logic      ready;
   axis_type  axis_out;
   value_type jerk_clamped;
   value_type accel_clamped;
   value_type velocity_clamped;
   value_type position_clamped;

   modport source (
      output valid, axis_out, jerk_clamped, accel_clamped, velocity_clamped,
             position_clamped,
      input  ready
   );

   modport sink (
      input  valid, axis_out, jerk_clamped, accel_clamped, velocity_clamped,
             position_clamped,
      output ready
   );

endinterface

[rtl/core/constrained_jerk_integrator.sv]
// Constrained jerk integrator: clamped cascaded Euler integration, one axis per item.
// Depends on cji_pkg, cji_req_if and cji_rsp_if.
//
//   Channel   Direction  Handshake         Carries
//   req_ch    in         valid / ready     axis, first_sample, jerk, initial values
//   rsp_ch    out        valid / ready     axis_out and the four clamped values
//   csr_*     in         csr_we only       register index and 60-bit write data
//
// An item is accepted in the idle state and walks through eleven sequencer steps; the
// result is loaded into the response register on the last one, and the next item is
// accepted only once the sequencer is back in idle. The single shared 21x25 multiplier
// performs the seven products of an item (three limits, the position margin and three
// dt integrations) one per cycle.
// Reset is synchronous and active high; it clears the sequencer, the response valid,
// the control registers and the per-axis sums. A stalled response only holds the last step.
module constrained_jerk_integrator #(
   parameter int AXES = 3
) (
   input  logic                             clock,
   input  logic                             reset,
   cji_req_if.sink                          req_ch,
   cji_rsp_if.source                        rsp_ch,
   input  logic                             csr_we,
   input  cji_pkg::csr_index_type           csr_index,
   input  logic [cji_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import cji_pkg::*;

   localparam int       AXIS_IDX_W = (AXES > 1) ? $clog2(AXES) : 1;
   localparam axis_type AXES_LIMIT = AXIS_W'(AXES);

   // Sequencer steps. Each step issues at most one product; it is consumed in the step after.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_JLIM,
      ST_JCLAMP,
      ST_ALIM,
      ST_ASUM,
      ST_VLIM,
      ST_HALF,
      ST_VSUM,
      ST_VCLAMP,
      ST_PMUL,
      ST_PSUM,
      ST_OUT
   } state_type;

   typedef logic signed [SUM_W-1:0] sum_type;

   // Clamp a value to plus or minus an unsigned limit, then to the output range.
   function automatic value_type clamp_lim(input value_type x, input logic [LANE_W-1:0] lim);
      logic signed [VAL_W+1:0] r;
      logic signed [VAL_W+1:0] lo;
      logic signed [VAL_W+1:0] hi;
      r  = {{2{x[VAL_W-1]}}, x};
      hi = $signed({2'b00, lim});
      lo = -hi;
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      if (r < -(22'sd524288)) r = -(22'sd524288);
      if (r > 22'sd524287) r = 22'sd524287;
      return r[VAL_W-1:0];
   endfunction

   // Add a scaled product to a running sum, saturating at the 40-bit range.
   function automatic sum_type sat_add(input sum_type s, input sum_type a);
      logic signed [SUM_W:0] t;
      t = {s[SUM_W-1], s} + {a[SUM_W-1], a};
      if (t[SUM_W] != t[SUM_W-1])
         return t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      return t[SUM_W-1:0];
   endfunction

   function automatic logic [LANE_W-1:0] lane_sel(input logic [PACKED_W-1:0] p,
                                                  input axis_type a);
      logic [LANE_W-1:0] r;
      case (a)
         2'd0:    r = p[LANE_W-1:0];
         2'd1:    r = p[2*LANE_W-1:LANE_W];
         default: r = p[3*LANE_W-1:2*LANE_W];
      endcase
      return r;
   endfunction

   // Control registers.
   logic [DT_W-1:0]     dt_ff;
   logic [MARGIN_W-1:0] margin_ff;
   logic [PACKED_W-1:0] jmax_ff;
   logic [PACKED_W-1:0] amax_ff;
   logic [PACKED_W-1:0] vmax_ff;
   logic [PACKED_W-1:0] pmin_ff;
   logic [PACKED_W-1:0] pmax_ff;

   // Per-axis running sums.
   sum_type asum_mem_ff [AXES];
   sum_type vsum_mem_ff [AXES];
   sum_type psum_mem_ff [AXES];

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   axis_type  rsp_axis_ff, rsp_axis_in;
   value_type rsp_jerk_ff, rsp_jerk_in;
   value_type rsp_accel_ff, rsp_accel_in;
   value_type rsp_vel_ff, rsp_vel_in;
   value_type rsp_pos_ff, rsp_pos_in;

   // Working registers of the item in flight.
   axis_type              axis_ff, axis_in;
   logic                  first_ff, first_in;
   value_type             jerk_ff, jerk_in;
   value_type             init_a_ff, init_a_in;
   value_type             init_v_ff, init_v_in;
   value_type             init_p_ff, init_p_in;
   value_type             j_ff, j_in;
   value_type             acc_ff, acc_in;
   value_type             vel_ff, vel_in;
   logic [LANE_W-1:0]     alim_ff, alim_in;
   logic [LANE_W-1:0]     vlim_ff, vlim_in;
   logic signed [VAL_W:0] half_ff, half_in;
   logic signed [VAL_W+1:0] lo_ff, lo_in;
   logic signed [VAL_W+1:0] hi_ff, hi_in;
   sum_type               asum_ff, asum_in;
   sum_type               vsum_ff, vsum_in;
   sum_type               psum_ff, psum_in;
   logic signed [45:0]    prod_ff, prod_in;

   // Shared multiplier operands.
   logic signed [20:0]    op_a;
   logic signed [24:0]    op_b;

   logic                    accept;
   logic                    in_range;
   logic                    out_fire;
   logic [MARGIN_W:0]       keep;
   logic [LANE_W-1:0]       prod_lim;
   sum_type                 prod_step;
   value_type               pmin_lane;
   value_type               pmax_lane;
   logic signed [VAL_W:0]   pos_span;
   logic signed [VAL_W+1:0] pos_wide;
   logic [AXIS_IDX_W-1:0]   req_idx;
   logic [AXIS_IDX_W-1:0]   cur_idx;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign in_range     = (req_ch.axis < AXES_LIMIT);
   assign out_fire     = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_idx      = req_ch.axis[AXIS_IDX_W-1:0];
   assign cur_idx      = axis_ff[AXIS_IDX_W-1:0];

   // (1 - margin) in Q1.16, and the product read back as a limit or an integration step.
   assign keep      = 17'h10000 - {1'b0, margin_ff};
   assign prod_lim  = prod_ff[35:16];
   assign prod_step = prod_ff[43:4];

   assign pmin_lane = $signed(lane_sel(pmin_ff, axis_ff));
   assign pmax_lane = $signed(lane_sel(pmax_ff, axis_ff));
   assign pos_span  = {pmax_lane[VAL_W-1], pmax_lane} - {pmin_lane[VAL_W-1], pmin_lane};

   // Operand selection for the shared multiplier.
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (state_ff)
         ST_JLIM: begin
            op_a = $signed({1'b0, lane_sel(jmax_ff, axis_ff)});
            op_b = $signed({8'd0, keep});
         end
         ST_JCLAMP: begin
            op_a = $signed({1'b0, lane_sel(amax_ff, axis_ff)});
            op_b = $signed({8'd0, keep});
         end
         ST_ALIM: begin
            op_a = {j_ff[VAL_W-1], j_ff};
            op_b = $signed({1'b0, dt_ff});
         end
         ST_ASUM: begin
            op_a = $signed({1'b0, lane_sel(vmax_ff, axis_ff)});
            op_b = $signed({8'd0, keep});
         end
         ST_VLIM: begin
            op_a = pos_span;
            op_b = $signed({9'd0, margin_ff});
         end
         ST_HALF: begin
            op_a = {acc_ff[VAL_W-1], acc_ff};
            op_b = $signed({1'b0, dt_ff});
         end
         ST_PMUL: begin
            op_a = {vel_ff[VAL_W-1], vel_ff};
            op_b = $signed({1'b0, dt_ff});
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod_in = op_a * op_b;

   // Final position clamp: lower bound first, upper bound second, then the output range.
   always_comb begin
      pos_wide = {{2{psum_ff[SUM_W-1]}}, psum_ff[SUM_W-1:VAL_W]};
      if (pos_wide < lo_ff) pos_wide = lo_ff;
      if (pos_wide > hi_ff) pos_wide = hi_ff;
      if (pos_wide < -(22'sd524288)) pos_wide = -(22'sd524288);
      if (pos_wide > 22'sd524287) pos_wide = 22'sd524287;
   end

   // Sequencer next state and datapath next values.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_axis_in  = rsp_axis_ff;
      rsp_jerk_in  = rsp_jerk_ff;
      rsp_accel_in = rsp_accel_ff;
      rsp_vel_in   = rsp_vel_ff;
      rsp_pos_in   = rsp_pos_ff;
      axis_in      = axis_ff;
      first_in     = first_ff;
      jerk_in      = jerk_ff;
      init_a_in    = init_a_ff;
      init_v_in    = init_v_ff;
      init_p_in    = init_p_ff;
      j_in         = j_ff;
      acc_in       = acc_ff;
      vel_in       = vel_ff;
      alim_in      = alim_ff;
      vlim_in      = vlim_ff;
      half_in      = half_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      asum_in      = asum_ff;
      vsum_in      = vsum_ff;
      psum_in      = psum_ff;

      if (rsp_valid_ff && rsp_ch.ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               axis_in   = req_ch.axis;
               first_in  = req_ch.first_sample;
               jerk_in   = req_ch.jerk_sample;
               init_a_in = req_ch.init_accel;
               init_v_in = req_ch.init_velocity;
               init_p_in = req_ch.init_position;
               // An item for a missing axis is taken and dropped without a result.
               if (in_range) begin
                  asum_in  = asum_mem_ff[req_idx];
                  vsum_in  = vsum_mem_ff[req_idx];
                  psum_in  = psum_mem_ff[req_idx];
                  state_in = ST_JLIM;
               end
            end
         end
         ST_JLIM: begin
            state_in = ST_JCLAMP;
         end
         ST_JCLAMP: begin
            j_in     = clamp_lim(jerk_ff, prod_lim);
            state_in = ST_ALIM;
         end
         ST_ALIM: begin
            alim_in  = prod_lim;
            state_in = ST_ASUM;
         end
         ST_ASUM: begin
            // A first sample loads the initial value and skips the jerk step.
            asum_in  = first_ff ? {init_a_ff, {VAL_W{1'b0}}} : sat_add(asum_ff, prod_step);
            state_in = ST_VLIM;
         end
         ST_VLIM: begin
            vlim_in  = prod_lim;
            acc_in   = clamp_lim(asum_ff[SUM_W-1:VAL_W], alim_ff);
            state_in = ST_HALF;
         end
         ST_HALF: begin
            half_in  = prod_ff[37:17];
            state_in = ST_VSUM;
         end
         ST_VSUM: begin
            vsum_in  = first_ff ? {init_v_ff, {VAL_W{1'b0}}} : sat_add(vsum_ff, prod_step);
            lo_in    = {{2{pmin_lane[VAL_W-1]}}, pmin_lane} + {half_ff[VAL_W], half_ff};
            hi_in    = {{2{pmax_lane[VAL_W-1]}}, pmax_lane} - {half_ff[VAL_W], half_ff};
            state_in = ST_VCLAMP;
         end
         ST_VCLAMP: begin
            vel_in   = clamp_lim(vsum_ff[SUM_W-1:VAL_W], vlim_ff);
            state_in = ST_PMUL;
         end
         ST_PMUL: begin
            state_in = ST_PSUM;
         end
         ST_PSUM: begin
            psum_in  = first_ff ? {init_p_ff, {VAL_W{1'b0}}} : sat_add(psum_ff, prod_step);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // Wait here only while the previous result has not been taken.
            if (out_fire) begin
               rsp_valid_in = 1'b1;
               rsp_axis_in  = axis_ff;
               rsp_jerk_in  = j_ff;
               rsp_accel_in = acc_ff;
               rsp_vel_in   = vel_ff;
               rsp_pos_in   = pos_wide[VAL_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer state and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_axis_ff  <= rsp_axis_in;
         rsp_jerk_ff  <= rsp_jerk_in;
         rsp_accel_ff <= rsp_accel_in;
         rsp_vel_ff   <= rsp_vel_in;
         rsp_pos_ff   <= rsp_pos_in;
      end
   end

   // Working registers and the product register.
   always_ff @(posedge clock) begin
      axis_ff   <= axis_in;
      first_ff  <= first_in;
      jerk_ff   <= jerk_in;
      init_a_ff <= init_a_in;
      init_v_ff <= init_v_in;
      init_p_ff <= init_p_in;
      j_ff      <= j_in;
      acc_ff    <= acc_in;
      vel_ff    <= vel_in;
      alim_ff   <= alim_in;
      vlim_ff   <= vlim_in;
      half_ff   <= half_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      asum_ff   <= asum_in;
      vsum_ff   <= vsum_in;
      psum_ff   <= psum_in;
      prod_ff   <= prod_in;
   end

   // Control registers and the per-axis sums, written back when the result is loaded for output.
   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff     <= STEP_TIME_RESET;
         margin_ff <= '0;
         jmax_ff   <= '0;
         amax_ff   <= '0;
         vmax_ff   <= '0;
         pmin_ff   <= '0;
         pmax_ff   <= '0;
         for (int i = 0; i < AXES; i++) begin
            asum_mem_ff[i] <= '0;
            vsum_mem_ff[i] <= '0;
            psum_mem_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_STEP_TIME:     dt_ff     <= csr_wdata[DT_W-1:0];
               REG_SAFETY_MARGIN: margin_ff <= csr_wdata[MARGIN_W-1:0];
               REG_JERK_MAX:      jmax_ff   <= csr_wdata[PACKED_W-1:0];
               REG_ACCEL_MAX:     amax_ff   <= csr_wdata[PACKED_W-1:0];
               REG_VELOCITY_MAX:  vmax_ff   <= csr_wdata[PACKED_W-1:0];
               REG_POSITION_MIN:  pmin_ff   <= csr_wdata[PACKED_W-1:0];
               REG_POSITION_MAX:  pmax_ff   <= csr_wdata[PACKED_W-1:0];
               default: ;
            endcase
         end
         if (out_fire) begin
            asum_mem_ff[cur_idx] <= asum_ff;
            vsum_mem_ff[cur_idx] <= vsum_ff;
            psum_mem_ff[cur_idx] <= psum_ff;
         end
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.axis_out         = rsp_axis_ff;
   assign rsp_ch.jerk_clamped     = rsp_jerk_ff;
   assign rsp_ch.accel_clamped    = rsp_accel_ff;
   assign rsp_ch.velocity_clamped = rsp_vel_ff;
   assign rsp_ch.position_clamped = rsp_pos_ff;

endmodule
